FILE: sv/rch_pkg.sv
// Shared types, sizes and codes for the RGB color histogram.
package rch_pkg;

    localparam int MAX_BINS    = 16;
    localparam int MIN_BINS    = 10;
    localparam int COUNT_WIDTH = 32;
    localparam int STORE_DEPTH = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field widths
    localparam int CHAN_W      = 8;
    localparam int IDX_W       = 12;
    localparam int OUT_COUNT_W = 32;
    localparam int BINS_W      = 5;

    // quantizer: ten levels per channel, 0..9
    localparam int LEVEL_W   = 4;
    localparam int LEVEL_MAX = 9;
    localparam int T1_MAX    = LEVEL_MAX + MAX_BINS * LEVEL_MAX;
    localparam int T1_W      = $clog2(T1_MAX + 1);
    localparam int SUM_MAX   = LEVEL_MAX + MAX_BINS * T1_MAX;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);

    localparam logic [BINS_W-1:0]      BINS_RESET = BINS_W'(MIN_BINS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [IDX_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]       bin_index;
        logic [OUT_COUNT_W-1:0] bin_count;
    } out_item_t;

    // bin request from the index stage to the update stage
    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic             in_range;
    } bin_req_t;

endpackage

FILE: sv/rch_ram.sv
// Simple dual-port synchronous RAM, registered read, one write port.
module rch_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/rch_index.sv
// Bin index stage: quantizes RGB and forms qr + B*(qg + B*qb) over two steps.
module rch_index
    import rch_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    input  logic [BINS_W-1:0] bins_cfg,
    output bin_req_t          req,
    input  logic              req_ready
);

    // (v*10)>>8, i.e. floor(v/25.6)
    function automatic logic [LEVEL_W-1:0] quantize(input logic [CHAN_W-1:0] v);
        logic [CHAN_W+3:0] prod;
        prod = {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
        return prod[CHAN_W+3 -: LEVEL_W];
    endfunction

    logic [BINS_W-1:0]  b_eff;
    logic [LEVEL_W-1:0] qr, qg, qb;
    logic [T1_W-1:0]    t1_next;
    logic [SUM_W-1:0]   sum;

    logic               v1_reg;
    logic               mode1_reg;
    logic [LEVEL_W-1:0] qr1_reg;
    logic [T1_W-1:0]    t1_reg;
    logic [IDX_W-1:0]   ridx1_reg;

    always_comb begin
        priority if (bins_cfg < BINS_W'(MIN_BINS)) begin
            b_eff = BINS_W'(MIN_BINS);
        end else if (bins_cfg > BINS_W'(MAX_BINS)) begin
            b_eff = BINS_W'(MAX_BINS);
        end else begin
            b_eff = bins_cfg;
        end
    end

    assign qr      = quantize(in_item.red);
    assign qg      = quantize(in_item.green);
    assign qb      = quantize(in_item.blue);
    assign t1_next = T1_W'(T1_W'(b_eff) * T1_W'(qb)) + T1_W'(qg);

    assign in_ready = !v1_reg || req_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            mode1_reg <= in_item.mode;
            qr1_reg   <= qr;
            t1_reg    <= t1_next;
            ridx1_reg <= in_item.read_index;
        end
    end

    // second multiply feeds the RAM read address, registered there
    assign sum = SUM_W'(SUM_W'(b_eff) * SUM_W'(t1_reg)) + SUM_W'(qr1_reg);

    always_comb begin
        req.valid = v1_reg;
        req.mode  = mode1_reg;
        if (mode1_reg == MODE_READ) begin
            req.idx      = ridx1_reg;
            req.in_range = 32'(ridx1_reg) < STORE_DEPTH;
        end else begin
            req.idx      = IDX_W'(sum);
            req.in_range = 32'(sum) < STORE_DEPTH;
        end
    end

endmodule

FILE: sv/rgb_color_histogram.sv
// Top level of the RGB color histogram: bin store, update stage, output register.
//
// Accumulates a 3-D color histogram of 8-bit RGB pixels. Each channel is
// quantized to ten levels, floor(v/25.6), and the bin qr + B*(qg + B*qb) has
// its counter incremented (saturating); B is the bins_per_axis register,
// clamped to 10..16. A read transaction (mode 1) returns the count of
// read_index and zeroes that bin. Every input transaction yields exactly one
// result transaction. After reset the block sweeps all 4096 counters to zero,
// one per cycle, and s_ready stays low until the sweep ends; bins_per_axis may be
// written during that time and should otherwise only be changed while idle.
// Throughput is one transaction per cycle while the output is not stalled, set by
// the read-modify-write on the counter RAM (one read port, one write port); a
// result passes through the index register, the RAM read register and then the
// output register.
// Back-to-back hits on the same bin are handled by forwarding the last
// written counter into the update stage.
module rgb_color_histogram
    import rch_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [BINS_W-1:0] cfg_wr_data,
    // pixel / read requests
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [BINS_W-1:0]   bins_reg;

    bin_req_t            req;
    logic                idx_in_ready;
    logic                idx_in_valid;

    // update stage (item whose RAM read data is now available)
    logic                v2_reg;
    logic                mode2_reg;
    logic [IDX_W-1:0]    idx2_reg;
    logic                inrange2_reg;
    logic                s2_go;
    logic                s2_free;

    // last RAM write, for forwarding
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [COUNT_WIDTH-1:0] res_count;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;

    logic                m_valid_reg;
    out_item_t           m_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg <= BINS_RESET;
        end else if (cfg_wr_en) begin
            bins_reg <= cfg_wr_data;
        end
    end

    // ---------------- clearing sweep after reset ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    clr_addr_reg <= clr_addr_reg;
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // ---------------- index stage ----------------
    assign s_ready      = (state_reg == ST_RUN) && idx_in_ready;
    assign idx_in_valid = s_valid && (state_reg == ST_RUN);

    rch_index u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (idx_in_valid),
        .in_ready  (idx_in_ready),
        .in_item   (s_data),
        .bins_cfg  (bins_reg),
        .req       (req),
        .req_ready (s2_free)
    );

    // ---------------- update stage ----------------
    // s2 leaves when the output register is empty or being drained
    assign s2_go   = v2_reg && (!m_valid_reg || m_ready);
    assign s2_free = !v2_reg || s2_go;
    // RAM output register only moves with the item entering s2
    assign ram_re  = req.valid && s2_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (s2_free) begin
            v2_reg <= req.valid;
        end
        if (ram_re) begin
            mode2_reg    <= req.mode;
            idx2_reg     <= req.idx;
            inrange2_reg <= req.in_range;
        end
    end

    // latest write to this bin wins over the RAM data (covers the write
    // that lands in the same cycle as our read)
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == idx2_reg[ADDR_W-1:0])) begin
            cur_count = fwd_data_reg;
        end else begin
            cur_count = ram_rdata;
        end
        inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);
        unique case (mode2_reg)
            MODE_ACCUM: begin
                new_count = inc_count;
                res_count = inc_count;
            end
            MODE_READ: begin
                new_count = '0;
                res_count = cur_count;
            end
            default: begin
                new_count = '0;
                res_count = '0;
            end
        endcase
        if (!inrange2_reg) begin
            res_count = '0;
        end
    end

    // write port: sweep during clear, update stage otherwise
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s2_go && inrange2_reg;
            ram_waddr = idx2_reg[ADDR_W-1:0];
            ram_wdata = new_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ram_we) begin
            fwd_valid_reg <= 1'b1;
        end
        if (ram_we) begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
    end

    rch_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (req.idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (s2_go) begin
            m_data_reg.bin_index <= idx2_reg;
            m_data_reg.bin_count <= OUT_COUNT_W'(res_count);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    a_no_item_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!v2_reg && !req.valid))
        else $error("transaction in flight during clearing sweep");

    a_result_follows_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_go |=> m_valid_reg)
        else $error("update stage advanced without a result");

    a_read_clears_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_go && inrange2_reg && (mode2_reg == MODE_READ)) |=> (fwd_data_reg == '0))
        else $error("read transaction did not zero its bin");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_go && !inrange2_reg) |=> (m_data_reg.bin_count == '0))
        else $error("out-of-store bin returned nonzero count");

    a_accum_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_go && inrange2_reg && (mode2_reg == MODE_ACCUM)) |-> (new_count != '0))
        else $error("accumulate wrote a zero count");

endmodule
